### hw/rtl/mteq_pkg.sv
// Package for the multi-timer expiry queue: sizes, op and result codes.
// No dependencies.
package mteq_pkg;
   localparam int NTimers   = 16;
   localparam int TickBits  = 32;
   localparam int IdW       = 4;
   localparam int PosW      = $clog2(NTimers);
   localparam int CntW      = $clog2(NTimers + 1);

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      K_STARTED  = 3'd0,
      K_REJECTED = 3'd1,
      K_STOPPED  = 3'd2,
      K_EXPIRED  = 3'd3,
      K_TICKDONE = 3'd4
   } kind_type;
endpackage

### hw/rtl/mteq_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module mteq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### hw/rtl/multi_timer_expiry_queue.sv
// Top level of the multi-timer expiry queue: sequencer, order list and expiry RAMs.
// Depends on mteq_pkg and mteq_ram.
//
//  channel | direction | ports
//  req     | in        | req_valid req_ready req_op req_timer_id req_timeout req_raw_ticks
//  rsp     | out       | rsp_valid rsp_ready rsp_kind rsp_timer_slot rsp_was_running
//          |           | rsp_wait_ticks rsp_last
//
// One item is worked on at a time. A start compares list entries one by one
// (order RAM read, expiry RAM read, compare) and then shifts the tail right one
// entry at a time. A stop scans the list and shifts the rest left. A tick removes
// each expired timer from the head of the list, and each removal shifts the whole
// list; a final beat ends the tick.
// Every result beat goes through one output register; the next beat of a tick is
// loaded only once the held one is taken, and no request is accepted while a beat
// is held. Reset clears the running flags, the count and the tick extension; the
// RAMs are not cleared because entries are only read after being written.
module multi_timer_expiry_queue
   import mteq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_timer_id,
   input  logic [31:0] req_timeout,
   input  logic [31:0] req_raw_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_timer_slot,
   output logic        rsp_was_running,
   output logic [31:0] rsp_wait_ticks,
   output logic        rsp_last
);
   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_DECODE = 11'b00000000010,
      S_RDORD  = 11'b00000000100,
      S_RDEXP  = 11'b00000001000,
      S_CMP    = 11'b00000010000,
      S_INS    = 11'b00000100000,
      S_SHR    = 11'b00001000000,
      S_SHL    = 11'b00010000000,
      S_SHLW   = 11'b00100000000,
      S_EMIT   = 11'b01000000000,
      S_WAIT   = 11'b10000000000
   } state_type;

   localparam logic [63:0] Wrap = 64'd1 << TickBits;
   localparam logic [TickBits-1:0] Half = {1'b0, {(TickBits-1){1'b1}}};

   state_type state_ff, state_in, after_ff, after_in;
   logic [NTimers-1:0] run_ff, run_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [63:0] base_ff, base_in, now_ff, now_in, exp_ff, exp_in;
   logic armed_ff, armed_in;
   op_type op_ff, op_in;
   logic [IdW-1:0] id_ff, id_in, cur_ff, cur_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic stop_found_ff, stop_found_in;

   logic rv_ff, rv_in, rl_ff, rl_in, rw_ff, rw_in;
   logic [2:0] rk_ff, rk_in;
   logic [3:0] rs_ff, rs_in;
   logic [31:0] rt_ff, rt_in;

   // order RAM ports
   logic ord_we;
   logic [PosW-1:0] ord_wa, ord_ra;
   logic [IdW-1:0] ord_wd, ord_rd;
   // expiry RAM ports
   logic exp_we;
   logic [IdW-1:0] exp_wa, exp_ra;
   logic [63:0] exp_wd, exp_rd;

   mteq_ram #(.Width(IdW), .Depth(NTimers)) u_ord (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
      .rd_addr(ord_ra), .rd_data(ord_rd));
   mteq_ram #(.Width(64), .Depth(NTimers)) u_exp (
      .clock(clock), .wr_en(exp_we), .wr_addr(exp_wa), .wr_data(exp_wd),
      .rd_addr(exp_ra), .rd_data(exp_rd));

   logic [TickBits-1:0] t_smp;
   logic [63:0] diff;

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_kind = rk_ff;
   assign rsp_timer_slot = rs_ff;
   assign rsp_was_running = rw_ff;
   assign rsp_wait_ticks = rt_ff;
   assign rsp_last = rl_ff;

   assign t_smp = req_raw_ticks[TickBits-1:0];
   assign diff = exp_rd - now_ff;

   always_comb begin
      state_in = state_ff; after_in = after_ff; run_in = run_ff; cnt_in = cnt_ff;
      base_in = base_ff; armed_in = armed_ff; now_in = now_ff; exp_in = exp_ff;
      op_in = op_ff; id_in = id_ff; cur_in = cur_ff; pos_in = pos_ff;
      stop_found_in = stop_found_ff;
      rv_in = rv_ff; rk_in = rk_ff; rs_in = rs_ff; rw_in = rw_ff; rt_in = rt_ff;
      rl_in = rl_ff;
      ord_we = 1'b0; ord_wa = pos_ff[PosW-1:0]; ord_wd = cur_ff;
      ord_ra = pos_ff[PosW-1:0];
      exp_we = 1'b0; exp_wa = id_ff; exp_wd = exp_ff; exp_ra = ord_rd;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = op_type'(req_op);
               id_in = req_timer_id;
               if (req_op == OP_START || req_op == OP_TICK) begin
                  if (armed_ff && t_smp < Half) begin
                     armed_in = 1'b0;
                     base_in = base_ff + Wrap;
                     now_in = base_ff + Wrap + 64'(t_smp);
                  end else begin
                     if (!armed_ff && t_smp > Half) begin
                        armed_in = 1'b1;
                     end
                     now_in = base_ff + 64'(t_smp);
                  end
               end
               exp_in = 64'(req_timeout);
               pos_in = '0;
               stop_found_in = 1'b0;
               if (req_op != OP_NONE) begin
                  state_in = S_DECODE;
               end
            end
         end
         S_DECODE: begin
            rw_in = 1'b0; rt_in = '0; rl_in = 1'b1; rs_in = id_ff;
            unique case (op_ff)
               OP_START: begin
                  if (run_ff[id_ff] || cnt_ff >= CntW'(NTimers)) begin
                     rk_in = K_REJECTED;
                     state_in = S_EMIT; after_in = S_IDLE;
                  end else begin
                     exp_in = now_ff + exp_ff;
                     state_in = S_RDORD;
                  end
               end
               OP_STOP: begin
                  rk_in = K_STOPPED;
                  if (!run_ff[id_ff]) begin
                     state_in = S_EMIT; after_in = S_IDLE;
                  end else begin
                     rw_in = 1'b1;
                     run_in[id_ff] = 1'b0;
                     state_in = S_RDORD;
                  end
               end
               OP_TICK: begin
                  state_in = S_RDORD;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RDORD: begin
            // ord_ra = pos; data valid next cycle
            if (pos_ff >= cnt_ff) begin
               if (op_ff == OP_START) begin
                  state_in = S_INS;
               end else if (op_ff == OP_TICK) begin
                  // The tick-done beat waits until the held beat is taken.
                  if (!rv_ff || rsp_ready) begin
                     rk_in = K_TICKDONE; rs_in = '0; rw_in = 1'b0; rl_in = 1'b1;
                     rt_in = '1;
                     state_in = S_EMIT; after_in = S_IDLE;
                  end
               end else begin
                  if (stop_found_ff) begin
                     cnt_in = cnt_ff - 1'b1;
                  end
                  state_in = S_EMIT; after_in = S_IDLE;
               end
            end else begin
               state_in = S_RDEXP;
            end
         end
         S_RDEXP: begin
            cur_in = ord_rd;
            if (op_ff == OP_STOP) begin
               if (ord_rd == id_ff) begin
                  // remove here: shift left from pos
                  stop_found_in = 1'b1;
                  state_in = S_SHL;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  state_in = S_RDORD;
               end
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (op_ff == OP_START) begin
               if (exp_rd <= exp_ff) begin
                  pos_in = pos_ff + 1'b1;
                  state_in = S_RDORD;
               end else begin
                  state_in = S_INS;
               end
            end else if (!rv_ff || rsp_ready) begin
               // The read addresses hold still, so the compare can wait here
               // until the output register is free.
               if (exp_rd <= now_ff) begin
                  run_in[cur_ff] = 1'b0;
                  rk_in = K_EXPIRED; rs_in = cur_ff; rw_in = 1'b0; rt_in = '0;
                  rl_in = 1'b0;
                  state_in = S_EMIT; after_in = S_SHL;
               end else begin
                  rk_in = K_TICKDONE; rs_in = '0; rw_in = 1'b0; rl_in = 1'b1;
                  rt_in = (diff[63:32] != 32'd0) ? '1 : diff[31:0];
                  state_in = S_EMIT; after_in = S_IDLE;
               end
            end
         end
         S_INS: begin
            // insert id at pos_ff: shift tail right from cnt-1 down to pos
            exp_we = 1'b1; exp_wa = id_ff; exp_wd = exp_ff;
            run_in[id_ff] = 1'b1;
            cur_in = id_ff;
            id_in = id_ff;
            after_in = S_IDLE;
            state_in = S_SHR;
            exp_in = 64'(cnt_ff);
         end
         S_SHR: begin
            // exp_ff low bits hold the index j being filled; walk j from cnt down
            if (exp_ff[CntW-1:0] == pos_ff) begin
               ord_we = 1'b1; ord_wa = pos_ff[PosW-1:0]; ord_wd = id_ff;
               cnt_in = cnt_ff + 1'b1;
               rk_in = K_STARTED; rs_in = id_ff; rw_in = 1'b0; rt_in = '0;
               rl_in = 1'b1;
               state_in = S_EMIT; after_in = S_IDLE;
            end else begin
               ord_ra = PosW'(exp_ff[CntW-1:0] - 1'b1);
               state_in = S_SHLW; after_in = S_SHR;
            end
         end
         S_SHL: begin
            // move entry pos+1 to pos; read it first
            if (pos_ff + 1'b1 >= cnt_ff) begin
               cnt_in = cnt_ff - 1'b1;
               if (op_ff == OP_STOP) begin
                  state_in = S_EMIT; after_in = S_IDLE;
               end else begin
                  pos_in = '0;
                  state_in = S_RDORD;
               end
            end else begin
               ord_ra = PosW'(pos_ff + 1'b1);
               state_in = S_SHLW; after_in = S_SHL;
            end
         end
         S_SHLW: begin
            ord_we = 1'b1;
            ord_wd = ord_rd;
            if (after_ff == S_SHR) begin
               ord_wa = exp_ff[PosW-1:0];
               exp_in = exp_ff - 64'd1;
            end else begin
               ord_wa = pos_ff[PosW-1:0];
               pos_in = pos_ff + 1'b1;
            end
            state_in = after_ff;
         end
         S_EMIT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               state_in = after_ff;
               if (after_ff == S_SHL) begin
                  pos_in = '0;
               end
            end
         end
         S_WAIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; after_ff <= S_IDLE; run_ff <= '0; cnt_ff <= '0;
         base_ff <= '0; armed_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; after_ff <= after_in; run_ff <= run_in;
         cnt_ff <= cnt_in; base_ff <= base_in; armed_ff <= armed_in; rv_ff <= rv_in;
      end
      now_ff <= now_in; exp_ff <= exp_in; op_ff <= op_in; id_ff <= id_in;
      cur_ff <= cur_in; pos_ff <= pos_in; stop_found_ff <= stop_found_in;
      rk_ff <= rk_in; rs_ff <= rs_in; rw_ff <= rw_in; rt_ff <= rt_in; rl_ff <= rl_in;
   end

   // Between items the pending count equals the number of running timers.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (cnt_ff == CntW'($countones(run_ff))))
      else $error("pending count differs from running timers");
   // No new beat is accepted while a result is still held.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_ready)
      else $error("request accepted with result pending");
   // The count never goes above the table size.
   a_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(NTimers))
      else $error("pending count overflow");
endmodule
